// ===== rtl/dtss_pkg.sv =====
`timescale 1ns / 1ps

package dtss_pkg;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_START_INCREMENT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_INCREMENT_STEP  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_LENGTH_SAMPLES  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ENVELOPE_STEP   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN            = 3'd4;

   // register widths
   localparam int START_INC_W = 31;
   localparam int INC_STEP_W  = 32;
   localparam int LENGTH_W    = 16;
   localparam int ENV_W       = 17;
   localparam int GAIN_W      = 16;

   // register reset values
   localparam logic [START_INC_W-1:0] START_INC_RESET = 31'd155826476;
   localparam logic [INC_STEP_W-1:0]  INC_STEP_RESET  = 32'd0;
   localparam logic [LENGTH_W-1:0]    LENGTH_RESET    = 16'd1764;
   localparam logic [ENV_W-1:0]       ENV_STEP_RESET  = 17'd37;
   localparam logic [GAIN_W-1:0]      GAIN_RESET      = 16'd26214;

   // envelope full scale, 1.0 in q1.16
   localparam logic [ENV_W-1:0] ENV_ONE = 17'h10000;

   // pi/2 in q2.30, seed for the sine series
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

endpackage

// ===== rtl/decaying_tone_sweep_synth.sv =====
`timescale 1ns / 1ps

// channel   | direction | handshake             | payload
// ----------+-----------+-----------------------+--------------------------------------
// req       | in        | req_valid / req_ready | req_restart
// rsp       | out       | rsp_valid / rsp_ready | rsp_sample, rsp_active, rsp_last
// csr       | in        | csr_valid / csr_ready | csr_index, csr_data
//
// a playing word reaches the result register after acceptance by way of one sine rom
// read, three passes through the one shared multiplier, then rounding into the output.
// an idle-voice word goes from acceptance straight to the output step. req_ready returns the cycle
// after the result is loaded, so no new word is taken while one is in progress.
// reset is synchronous and active high; it restores register defaults and silences the voice.
// a result held back by rsp_ready stalls the block in its final step; csr writes never stall.

module decaying_tone_sweep_synth #(
   parameter int PHASE_BITS     = 32,
   parameter int SINE_ADDR_BITS = 10,
   parameter int SAMPLE_BITS    = 16
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_restart,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]     rsp_sample,
   output logic                              rsp_active,
   output logic                              rsp_last,

   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dtss_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [dtss_pkg::CSR_DATA_W-1:0]   csr_data
);

   import dtss_pkg::*;

   localparam int QUARTER_BITS = SINE_ADDR_BITS - 2;
   localparam int QUARTER_LEN  = 2 ** QUARTER_BITS;
   localparam int ROM_W        = SAMPLE_BITS - 1;
   localparam int MUL_A_W      = (ROM_W > GAIN_W) ? ROM_W : GAIN_W;
   localparam int MUL_P_W      = MUL_A_W + ENV_W;
   localparam int P1_W         = ROM_W + ENV_W;
   localparam int ACC_W        = ROM_W + ENV_W + GAIN_W;
   localparam int RND_W        = ACC_W + 1 - 32;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_ROM  = 3'd1;
   localparam logic [2:0] S_MUL1 = 3'd2;
   localparam logic [2:0] S_MUL2 = 3'd3;
   localparam logic [2:0] S_MUL3 = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   // quarter-wave sine entry, truncated taylor series in q2.30
   function automatic logic [ROM_W-1:0] sine_entry(input int unsigned j);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] v;
      logic [63:0] maxs;
      maxs = (64'd1 << ROM_W) - 64'd1;
      x    = (HALF_PI_Q30 * (64'(2 * j) + 64'd1) + 64'(QUARTER_LEN)) >> (SINE_ADDR_BITS - 1);
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int k = 1; k <= 6; k++) begin
         term = (term * x2) >> 30;
         case (k)
            1: term = term / 64'd6;
            2: term = term / 64'd20;
            3: term = term / 64'd42;
            4: term = term / 64'd72;
            5: term = term / 64'd110;
            default: term = term / 64'd156;
         endcase
         if ((k % 2) == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      v = (sum * maxs + (64'd1 << 29)) >> 30;
      if (v > maxs) begin
         v = maxs;
      end
      return v[ROM_W-1:0];
   endfunction

   logic [ROM_W-1:0] sine_rom [QUARTER_LEN];

   for (genvar g = 0; g < QUARTER_LEN; g++) begin : g_rom
      assign sine_rom[g] = sine_entry(g);
   end

   // configuration registers
   logic [START_INC_W-1:0]       start_inc_ff;
   logic signed [INC_STEP_W-1:0] inc_step_ff;
   logic [LENGTH_W-1:0]          length_ff;
   logic [ENV_W-1:0]             env_step_ff;
   logic [GAIN_W-1:0]            gain_ff;

   // voice state
   logic [2:0]            state_ff, state_in;
   logic [LENGTH_W-1:0]   sample_index_ff;
   logic [PHASE_BITS-1:0] phase_acc_ff;
   logic [PHASE_BITS-1:0] phase_step_ff;
   logic [ENV_W-1:0]      env_ff;
   logic                  playing_ff;

   // datapath
   logic [ROM_W-1:0] rom_ff;
   logic             neg_ff;
   logic [P1_W-1:0]  p1_ff;
   logic [ACC_W-1:0] acc_ff;

   logic                    rsp_valid_ff;
   logic [SAMPLE_BITS-1:0]  rsp_sample_ff;
   logic                    rsp_active_ff;
   logic                    rsp_last_ff;

   logic                      accept;
   logic                      out_free;
   logic                      out_fire;
   logic [SINE_ADDR_BITS-1:0] addr;
   logic [QUARTER_BITS-1:0]   rom_idx;
   logic [MUL_A_W-1:0]        mul_a;
   logic [ENV_W-1:0]          mul_b;
   logic [MUL_P_W-1:0]        mul_p;
   logic [ACC_W:0]            rnd_sum;
   logic [RND_W-1:0]          rounded;
   logic [ROM_W-1:0]          mag_sat;
   logic [SAMPLE_BITS-1:0]    mag_ext;
   logic [SAMPLE_BITS-1:0]    signed_sample;
   logic                      is_last;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign out_fire  = (state_ff == S_OUT) && out_free;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;
   assign rsp_active = rsp_active_ff;
   assign rsp_last   = rsp_last_ff;

   // sine address, mirrored in odd quadrants
   assign addr    = phase_acc_ff[PHASE_BITS-1 -: SINE_ADDR_BITS];
   assign rom_idx = addr[SINE_ADDR_BITS-2] ? ~addr[QUARTER_BITS-1:0] : addr[QUARTER_BITS-1:0];

   // shared multiplier operand select
   always_comb begin
      case (state_ff)
         S_MUL1: begin
            mul_a = MUL_A_W'(rom_ff);
            mul_b = env_ff;
         end
         S_MUL2: begin
            mul_a = MUL_A_W'(p1_ff[ROM_W-1:0]);
            mul_b = ENV_W'(gain_ff);
         end
         S_MUL3: begin
            mul_a = MUL_A_W'(gain_ff);
            mul_b = p1_ff[P1_W-1:ROM_W];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

   // round half up at bit 32, clamp to full scale, then apply sign
   assign rnd_sum       = {1'b0, acc_ff} + (ACC_W + 1)'(64'h8000_0000);
   assign rounded       = rnd_sum[ACC_W:32];
   assign mag_sat       = (|rounded[RND_W-1:ROM_W]) ? '1 : rounded[ROM_W-1:0];
   assign mag_ext       = {1'b0, mag_sat};
   assign signed_sample = neg_ff ? (~mag_ext + 1'b1) : mag_ext;
   assign is_last       = ({1'b0, sample_index_ff} + 17'd1) >= {1'b0, length_ff};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = (req_restart || playing_ff) ? S_ROM : S_OUT;
            end
         end
         S_ROM:  state_in = S_MUL1;
         S_MUL1: state_in = S_MUL2;
         S_MUL2: state_in = S_MUL3;
         S_MUL3: state_in = S_OUT;
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         start_inc_ff    <= START_INC_RESET;
         inc_step_ff     <= INC_STEP_RESET;
         length_ff       <= LENGTH_RESET;
         env_step_ff     <= ENV_STEP_RESET;
         gain_ff         <= GAIN_RESET;
         sample_index_ff <= '0;
         phase_acc_ff    <= '0;
         phase_step_ff   <= '0;
         env_ff          <= '0;
         playing_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_START_INCREMENT: start_inc_ff <= csr_data[START_INC_W-1:0];
               REG_INCREMENT_STEP:  inc_step_ff  <= csr_data[INC_STEP_W-1:0];
               REG_LENGTH_SAMPLES:  length_ff    <= csr_data[LENGTH_W-1:0];
               REG_ENVELOPE_STEP:   env_step_ff  <= csr_data[ENV_W-1:0];
               REG_GAIN:            gain_ff      <= csr_data[GAIN_W-1:0];
               default: ;
            endcase
         end

         if (accept && req_restart) begin
            sample_index_ff <= '0;
            phase_acc_ff    <= '0;
            phase_step_ff   <= PHASE_BITS'(start_inc_ff);
            env_ff          <= ENV_ONE;
            playing_ff      <= 1'b1;
         end

         // advance the voice once its sample is handed over
         if (out_fire && playing_ff) begin
            phase_acc_ff    <= phase_acc_ff + phase_step_ff;
            phase_step_ff   <= phase_step_ff + PHASE_BITS'(inc_step_ff);
            env_ff          <= (env_ff >= env_step_ff) ? (env_ff - env_step_ff) : '0;
            sample_index_ff <= sample_index_ff + 1'b1;
            if (is_last) begin
               playing_ff <= 1'b0;
            end
         end

         if (out_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_ROM) begin
         rom_ff <= sine_rom[rom_idx];
         neg_ff <= addr[SINE_ADDR_BITS-1];
      end
      if (state_ff == S_MUL1) begin
         p1_ff <= mul_p[P1_W-1:0];
      end
      if (state_ff == S_MUL2) begin
         acc_ff <= ACC_W'(mul_p);
      end
      if (state_ff == S_MUL3) begin
         acc_ff <= acc_ff + (ACC_W'(mul_p) << ROM_W);
      end
      if (out_fire) begin
         rsp_sample_ff <= playing_ff ? signed_sample : '0;
         rsp_active_ff <= playing_ff;
         rsp_last_ff   <= playing_ff && is_last;
      end
   end

   a_idle_word_silent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_active) |-> (rsp_sample == '0 && !rsp_last))
      else $error("idle word carries a sample or last flag");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("new word taken while a sample is in progress");

   a_last_stops_voice: assert property (@(posedge clock) disable iff (reset)
      (out_fire && playing_ff && is_last) |=> !playing_ff)
      else $error("voice still playing after its last sample");

   a_env_in_range: assert property (@(posedge clock) disable iff (reset)
      env_ff <= ENV_ONE)
      else $error("envelope above full scale");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_sample)))
      else $error("result dropped or changed while stalled");

endmodule

// ===== tb/decaying_tone_sweep_synth_tb.sv =====
`timescale 1ns / 1ps

module decaying_tone_sweep_synth_tb;
   import dtss_pkg::*;

   localparam int PHASE_BITS     = 32;
   localparam int SINE_ADDR_BITS = 10;
   localparam int SAMPLE_BITS    = 16;
   localparam int QUARTER_LEN    = 1 << (SINE_ADDR_BITS - 2);
   localparam logic [63:0] PCM_MAX = (64'd1 << (SAMPLE_BITS - 1)) - 1;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int REPORT_LIMIT  = 10;
   localparam int LONG_HOLD     = 400;
   localparam int SETTLE_CYCLES = 20;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_WORDS   = 125;

   typedef enum int {RX_OPEN, RX_EVERY_FOURTH, RX_COIN, RX_SPARSE} rx_pattern_type;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] pcm;
      logic                          active;
      logic                          last;
   } voice_word_type;

   class voice_scoreboard_type;
      logic [START_INC_W-1:0] start_inc;
      logic [INC_STEP_W-1:0]  inc_step;
      logic [LENGTH_W-1:0]    note_len;
      logic [ENV_W-1:0]       env_step;
      logic [GAIN_W-1:0]      gain;

      logic [LENGTH_W-1:0]    pos;
      logic [PHASE_BITS-1:0]  phase;
      logic [PHASE_BITS-1:0]  phase_inc;
      logic [ENV_W-1:0]       env;
      bit                     sounding;

      logic [63:0]            quarter_sine [QUARTER_LEN];
      voice_word_type         due_samples [$];
      int                     mismatches;

      function new();
         logic [63:0] x, x2, term, series, v;
         start_inc  = START_INC_RESET;
         inc_step   = INC_STEP_RESET;
         note_len   = LENGTH_RESET;
         env_step   = ENV_STEP_RESET;
         gain       = GAIN_RESET;
         pos        = '0;
         phase      = '0;
         phase_inc  = '0;
         env        = '0;
         sounding   = 1'b0;
         mismatches = 0;
         // sine by taylor series in q2.30, angle at the centre of each entry
         for (int j = 0; j < QUARTER_LEN; j++) begin
            x = (HALF_PI_Q30 * (2 * j + 1) + QUARTER_LEN) / (2 * QUARTER_LEN);
            x2 = (x * x) >> 30;
            term = x;
            series = x;
            for (int k = 1; k <= 6; k++) begin
               term = (term * x2) >> 30;
               term = term / ((2 * k) * (2 * k + 1));
               if (k % 2 == 1)
                  series = series - term;
               else
                  series = series + term;
            end
            v = (series * PCM_MAX + (64'd1 << 29)) >> 30;
            if (v > PCM_MAX)
               v = PCM_MAX;
            quarter_sine[j] = v;
         end
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_START_INCREMENT: start_inc = data[START_INC_W-1:0];
            REG_INCREMENT_STEP:  inc_step  = data[INC_STEP_W-1:0];
            REG_LENGTH_SAMPLES:  note_len  = data[LENGTH_W-1:0];
            REG_ENVELOPE_STEP:   env_step  = data[ENV_W-1:0];
            REG_GAIN:            gain      = data[GAIN_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_request(logic restart);
         voice_word_type            w;
         logic [SINE_ADDR_BITS-1:0] addr;
         logic [SINE_ADDR_BITS-3:0] tix;
         logic [63:0]               mag;
         logic                      fin;
         if (restart) begin
            pos       = '0;
            phase     = '0;
            phase_inc = PHASE_BITS'(start_inc);
            env       = ENV_ONE;
            sounding  = 1'b1;
         end
         if (!sounding) begin
            w.pcm    = '0;
            w.active = 1'b0;
            w.last   = 1'b0;
            due_samples.push_back(w);
            return;
         end
         addr = phase[PHASE_BITS-1 -: SINE_ADDR_BITS];
         tix = addr[SINE_ADDR_BITS-3:0];
         // odd quadrants read the table backwards
         if (addr[SINE_ADDR_BITS-2])
            tix = ~tix;
         mag = quarter_sine[tix] * env * gain;
         mag = (mag + (64'd1 << 31)) >> 32;
         if (mag > PCM_MAX)
            mag = PCM_MAX;
         w.pcm    = addr[SINE_ADDR_BITS-1] ? SAMPLE_BITS'(-mag) : SAMPLE_BITS'(mag);
         w.active = 1'b1;
         // a zero length makes every word the last one
         fin      = ({1'b0, pos} + 1'b1) >= {1'b0, note_len};
         w.last   = fin;
         due_samples.push_back(w);

         phase     = phase + phase_inc;
         phase_inc = phase_inc + PHASE_BITS'(signed'(inc_step));
         env       = (env >= env_step) ? env - env_step : '0;
         pos       = pos + 1'b1;
         if (fin)
            sounding = 1'b0;
      endfunction

      function void check_word(logic signed [SAMPLE_BITS-1:0] pcm, logic active, logic last);
         voice_word_type want;
         if (due_samples.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: word with none due: pcm %0d active %0b last %0b",
                        $time, pcm, active, last);
            return;
         end
         want = due_samples.pop_front();
         if (pcm !== want.pcm || active !== want.active || last !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: expected pcm %0d active %0b last %0b, got pcm %0d active %0b last %0b",
                        $time, want.pcm, want.active, want.last, pcm, active, last);
         end
      endfunction
   endclass

   logic                          clock       = 1'b0;
   logic                          reset       = 1'b1;
   logic                          req_valid   = 1'b0;
   logic                          req_ready;
   logic                          req_restart = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready   = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_sample;
   logic                          rsp_active;
   logic                          rsp_last;
   logic                          csr_valid   = 1'b0;
   logic                          csr_ready;
   logic [CSR_INDEX_W-1:0]        csr_index   = '0;
   logic [CSR_DATA_W-1:0]         csr_data    = '0;

   voice_scoreboard_type voice = new();

   int             burst_left   = 0;
   bit             steady       = 1'b0;
   bit             hold_request = 1'b0;
   bit             hold_taken   = 1'b0;
   int             hold_left    = 0;
   int             rx_tick      = 0;
   rx_pattern_type rx_mode      = RX_OPEN;
   int             cycle_count  = 0;

   decaying_tone_sweep_synth #(
      .PHASE_BITS     (PHASE_BITS),
      .SINE_ADDR_BITS (SINE_ADDR_BITS),
      .SAMPLE_BITS    (SAMPLE_BITS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_restart (req_restart),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_sample  (rsp_sample),
      .rsp_active  (rsp_active),
      .rsp_last    (rsp_last),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("decaying_tone_sweep_synth_tb: done, errors");
         $finish;
      end
   end

   // receiver: rotating stall patterns plus one long hold-off
   always @(posedge clock) begin
      rx_tick++;
      if (rx_tick % 150 == 0)
         rx_mode = rx_pattern_type'($urandom_range(0, 3));
      if (hold_request && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (rx_mode)
            RX_OPEN:         rsp_ready <= 1'b1;
            RX_EVERY_FOURTH: rsp_ready <= (rx_tick % 4 != 3);
            RX_COIN:         rsp_ready <= 1'($urandom_range(0, 1));
            default:         rsp_ready <= (rx_tick % 7 == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         voice.check_word(rsp_sample, rsp_active, rsp_last);
   end

   task automatic send_word(input logic restart);
      req_valid   <= 1'b1;
      req_restart <= restart;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      voice.note_request(restart);
   endtask

   task automatic offer(input logic restart);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = steady ? 0 : $urandom_range(0, 9);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      send_word(restart);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (voice.due_samples.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      voice.write_reg(idx, data);
   endtask

   task automatic load_settings(input logic [CSR_DATA_W-1:0] start_inc, inc_step, note_len,
                                env_step, gain_val);
      wait_drained();
      csr_write(REG_START_INCREMENT, start_inc);
      csr_write(REG_INCREMENT_STEP, inc_step);
      csr_write(REG_LENGTH_SAMPLES, note_len);
      csr_write(REG_ENVELOPE_STEP, env_step);
      csr_write(REG_GAIN, gain_val);
      // unmapped index, must be dropped
      csr_write(CSR_INDEX_W'(REG_GAIN + $urandom_range(1, 3)), $urandom);
      csr_valid <= 1'b0;
   endtask

   task automatic play_notes(input int words);
      int sent;
      int eff_len;
      int run;
      eff_len = (voice.note_len == 0) ? 1 : voice.note_len;
      // carry on a note left over from the last settings
      run = $urandom_range(0, 8);
      repeat (run) offer(1'b0);
      sent = run;
      while (sent < words) begin
         if ($urandom_range(0, 9) == 0) begin
            offer(1'($urandom_range(0, 1)));
            sent++;
         end else begin
            if ($urandom_range(0, 4) == 0)
               run = $urandom_range(0, eff_len - 1);
            else
               run = eff_len - 1 + $urandom_range(0, 3);
            if (run > 60)
               run = $urandom_range(20, 60);
            // keep the phase near its word budget
            if (run > words - sent - 1)
               run = words - sent - 1;
            offer(1'b1);
            repeat (run) offer(1'b0);
            sent += run + 1;
         end
      end
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] si, is, nl, es, gv;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // silent words, a note, then a restart while it sounds
      repeat (3) offer(1'b0);
      offer(1'b1);
      repeat (6) offer(1'b0);
      offer(1'b1);
      repeat (3) offer(1'b0);

      // zero length, full envelope drop, widest steps
      load_settings(32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0001_0000, 32'h0000_FFFF);
      offer(1'b1);
      offer(1'b0);
      offer(1'b1);
      offer(1'b0);

      // quarter-cycle steps visit three quadrants, envelope underflows at once
      load_settings(32'h4000_0000, 32'h0000_0000, 32'h0000_0003, 32'h0001_FFFF, 32'h0000_FFFF);
      offer(1'b1);
      repeat (4) offer(1'b0);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         si = $urandom;
         is = $urandom;
         gv = $urandom;
         nl = $urandom;
         nl[15:0] = $urandom_range(1, 40);
         es = $urandom;
         es[31:17] = '0;
         if ($urandom_range(0, 2) == 0)
            es[16:0] = $urandom_range(0, 4000);
         else
            es[16:0] = 65536 / nl[15:0] + $urandom_range(0, 2000);
         case (p)
            0: begin
               si = 32'hFFFF_FFFF;
               is = 32'h8000_0000;
               nl[15:0] = 16'hFFFF;
               es[16:0] = '0;
               gv[15:0] = 16'hFFFF;
            end
            1: begin
               si = '0;
               is = 32'h7FFF_FFFF;
               nl[15:0] = 16'd1;
               es[16:0] = 17'h10000;
               gv[15:0] = '0;
            end
            2: begin
               si[30:0] = '1;
               is = '0;
               nl[15:0] = '0;
               es[16:0] = '1;
            end
            3: begin
               // gentle sweep either way
               is = $urandom_range(0, 1 << 20);
               if ($urandom_range(0, 1) == 1)
                  is = -is;
            end
            default: ;
         endcase
         load_settings(si, is, nl, es, gv);
         steady = (p % 3 == 1);
         if (p == 4) begin
            // receiver blocks for a long stretch while words keep coming
            steady = 1'b1;
            hold_request = 1'b1;
         end
         play_notes(PHASE_WORDS);
      end
      steady = 1'b0;

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (voice.mismatches == 0 && voice.due_samples.size() == 0)
         $display("decaying_tone_sweep_synth_tb: done, clean");
      else
         $display("decaying_tone_sweep_synth_tb: done, errors");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/dtss_pkg.sv
rtl/decaying_tone_sweep_synth.sv
tb/decaying_tone_sweep_synth_tb.sv
